@@ rtl/core/bkl_pkg.sv @@
`default_nettype none

package bkl_pkg;

    localparam int DEF_MAX_REQUESTERS = 32;
    localparam int DEF_TICKET_BITS    = 16;

    localparam int ID_W         = 5;
    localparam int CNT_W        = 6;
    localparam int TICKET_OUT_W = 16;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(32);

    typedef enum logic [0:0] {
        FUNC_LOCK    = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_BAD_ID   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAX_SCAN,
        ST_UPDATE,
        ST_MIN_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        func_t           func;
        logic [ID_W-1:0] requester_id;
    } in_item_t;

    typedef struct packed {
        status_t                 status;
        logic [TICKET_OUT_W-1:0] ticket_given;
        logic                    owner_valid;
        logic [ID_W-1:0]         owner_id;
    } out_item_t;

    // control from the sequencer to the shared compare unit
    typedef struct packed {
        logic clear;
        logic step;
        logic mode_min;
    } scan_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/bkl_ram.sv @@
`default_nettype none

module bkl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bkl_scan_unit.sv @@
`default_nettype none

module bkl_scan_unit
    import bkl_pkg::*;
#(
    parameter int TICKET_BITS = DEF_TICKET_BITS,
    parameter int AW          = 5
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire scan_ctrl_t             ctrl,
    input  wire logic [TICKET_BITS-1:0] ticket,
    input  wire logic [AW-1:0]          index,
    output logic      [TICKET_BITS-1:0] best,
    output logic      [AW-1:0]          best_idx,
    output logic                        found
);

    logic [TICKET_BITS-1:0] best_reg;
    logic [AW-1:0]          best_idx_reg;
    logic                   found_reg;
    logic [TICKET_BITS-1:0] cmp_a;
    logic [TICKET_BITS-1:0] cmp_b;
    logic                   cmp_lt;
    logic                   take;

    // one magnitude comparator serves both the maximum and the minimum pass
    always_comb
    begin
        cmp_a  = ctrl.mode_min ? ticket : best_reg;
        cmp_b  = ctrl.mode_min ? best_reg : ticket;
        cmp_lt = cmp_a < cmp_b;
        if (ctrl.mode_min)
        begin
            // strict compare keeps the lower id on a tie
            take = (ticket != '0) && (!found_reg || cmp_lt);
        end
        else
        begin
            take = cmp_lt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.step && take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            best_reg     <= '0;
            best_idx_reg <= '0;
        end
        else if (ctrl.step && take)
        begin
            best_reg     <= ticket;
            best_idx_reg <= index;
        end
    end

    assign best     = best_reg;
    assign best_idx = best_idx_reg;
    assign found    = found_reg;

endmodule

`default_nettype wire

@@ rtl/core/bakery_ticket_lock_arbiter.sv @@
`default_nettype none

// Bakery ticket lock arbiter. Each item is a lock or release from one requester; the block
// answers with one result giving the status, the ticket handed out and the current owner
// (smallest nonzero ticket, lower id on a tie). The tickets sit in a RAM that is scanned one
// entry a cycle through one shared comparator, and in_ready is high only while the
// sequencer is idle. Each pass reads n = min(requester_count, MAX_REQUESTERS) entries; a
// lock runs a maximum pass, the update, then an owner pass, a release the update and an
// owner pass, and a refused id the owner pass alone; the next item can be taken in the
// cycle after the result is loaded. A finished result waits in the output register while
// the next item is taken; a result still waiting there when the next one is ready holds
// the sequencer in its last step until out_ready. Per-entry valid bits clear the store at
// reset at once, so there is no clearing pass.

module bakery_ticket_lock_arbiter
    import bkl_pkg::*;
#(
    parameter int MAX_REQUESTERS = DEF_MAX_REQUESTERS,
    parameter int TICKET_BITS    = DEF_TICKET_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_data
);

    localparam int AW = $clog2(MAX_REQUESTERS);
    localparam int NW = $clog2(MAX_REQUESTERS + 1);
    localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [NW-1:0]           n_eff;
    func_t                   func_reg;
    logic [AW-1:0]           id_reg;
    logic [NW-1:0]           idx_reg;
    logic [NW-1:0]           idx_next;
    logic                    rd_pend_reg;
    logic                    rd_ok_reg;
    logic [AW-1:0]           rd_idx_reg;
    logic [MAX_REQUESTERS-1:0] valid_reg;
    status_t                 status_reg;
    status_t                 status_next;
    logic [TICKET_BITS-1:0]  given_reg;
    logic [TICKET_BITS-1:0]  given_next;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;
    out_item_t               out_data_next;

    logic                    accept;
    logic                    bad_id;
    logic                    issue;
    logic                    load_out;
    logic                    ram_wr_en;
    logic                    set_valid;
    logic                    clr_valid;
    logic [AW-1:0]           rd_addr;
    logic [TICKET_BITS-1:0]  rd_data;
    logic [TICKET_BITS-1:0]  scan_ticket;
    scan_ctrl_t              scan_ctrl;
    logic [TICKET_BITS-1:0]  scan_best;
    logic [AW-1:0]           scan_best_idx;
    logic                    scan_found;
    logic                    overflow;
    logic [TICKET_BITS-1:0]  new_ticket;
    logic [31:0]             given_wide;
    logic [31:0]             owner_wide;

    always_comb
    begin
        if (32'(count_reg) > MAX_REQUESTERS)
        begin
            n_eff = NW'(MAX_REQUESTERS);
        end
        else
        begin
            n_eff = NW'(count_reg);
        end
    end

    assign accept      = in_valid && in_ready;
    assign bad_id      = 32'(in_data.requester_id) >= 32'(n_eff);
    assign issue       = ((state_reg == ST_MAX_SCAN) || (state_reg == ST_MIN_SCAN))
                         && (idx_reg < n_eff);
    assign rd_addr     = idx_reg[AW-1:0];
    assign scan_ticket = rd_ok_reg ? rd_data : '0;
    assign overflow    = scan_best == TICKET_TOP;
    assign new_ticket  = scan_best + 1'b1;
    assign given_wide  = 32'(given_reg);
    assign owner_wide  = 32'(scan_best_idx);

    bkl_ram #(
        .WIDTH (TICKET_BITS),
        .DEPTH (MAX_REQUESTERS)
    ) u_ticket_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (id_reg),
        .wr_data (new_ticket),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bkl_scan_unit #(
        .TICKET_BITS (TICKET_BITS),
        .AW          (AW)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .ticket   (scan_ticket),
        .index    (rd_idx_reg),
        .best     (scan_best),
        .best_idx (scan_best_idx),
        .found    (scan_found)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_RESET;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= issue;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            if (set_valid)
            begin
                valid_reg[id_reg] <= 1'b1;
            end
            else if (clr_valid)
            begin
                valid_reg[id_reg] <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        given_reg  <= given_next;
        if (accept)
        begin
            func_reg <= in_data.func;
            id_reg   <= AW'(in_data.requester_id);
        end
        if (issue)
        begin
            rd_ok_reg  <= valid_reg[rd_addr];
            rd_idx_reg <= rd_addr;
        end
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        status_next        = status_reg;
        given_next         = given_reg;
        in_ready           = 1'b0;
        load_out           = 1'b0;
        ram_wr_en          = 1'b0;
        set_valid          = 1'b0;
        clr_valid          = 1'b0;
        scan_ctrl.clear    = 1'b0;
        scan_ctrl.step     = rd_pend_reg;
        scan_ctrl.mode_min = state_reg == ST_MIN_SCAN;

        out_data_next.status       = status_reg;
        out_data_next.ticket_given = given_wide[TICKET_OUT_W-1:0];
        out_data_next.owner_valid  = scan_found;
        out_data_next.owner_id     = scan_found ? owner_wide[ID_W-1:0] : '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    scan_ctrl.clear = 1'b1;
                    idx_next        = '0;
                    given_next      = '0;
                    status_next     = STATUS_OK;
                    if (bad_id)
                    begin
                        status_next = STATUS_BAD_ID;
                        state_next  = ST_MIN_SCAN;
                    end
                    else if (in_data.func == FUNC_LOCK)
                    begin
                        state_next = ST_MAX_SCAN;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_MAX_SCAN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    // last read drains this cycle, the maximum is final next cycle
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                scan_ctrl.clear = 1'b1;
                idx_next        = '0;
                state_next      = ST_MIN_SCAN;
                if (func_reg == FUNC_RELEASE)
                begin
                    clr_valid = 1'b1;
                end
                else if (overflow)
                begin
                    status_next = STATUS_OVERFLOW;
                end
                else
                begin
                    ram_wr_en  = 1'b1;
                    set_valid  = 1'b1;
                    given_next = new_ticket;
                end
            end
            ST_MIN_SCAN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside the finish step");

    a_no_owner_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.owner_valid) |-> (out_data.owner_id == '0))
        else $error("owner id set without an owner");

    a_refused_no_ticket: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != STATUS_OK)) |-> (out_data.ticket_given == '0))
        else $error("refused item carries a ticket");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> ((state_reg == ST_MAX_SCAN) || (state_reg == ST_MIN_SCAN)))
        else $error("ticket read pending outside a scan");

    a_write_not_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (!overflow && (state_reg == ST_UPDATE)))
        else $error("ticket written on overflow");

endmodule

`default_nettype wire
